// ===== sv/dha_pkg.sv =====
`default_nettype none

package dha_pkg;

	// field widths of the request and response items
	localparam int REQ_W  = 2;
	localparam int LD_W   = 32;
	localparam int PID_W  = 16;
	localparam int NODE_W = 16;
	localparam int DESC_W = 11;
	localparam int ST_W   = 2;

	// default table depth
	localparam int DHA_DEPTH = 1024;

	// in-use bitmap word width and its bit index width
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GET   = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic latch_req;
		logic issue_rd;
		logic commit;
		logic load_fail;
	} dha_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic needs_mem;
	} dha_sts_t;

endpackage

`default_nettype wire

// ===== sv/dha_ram.sv =====
`default_nettype none

module dha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/dha_ctrl.sv =====
`default_nettype none

module dha_ctrl import dha_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output dha_cmd_t      cmd,
	input  wire dha_sts_t sts
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_MEM   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	// output register can take a new item
	assign slot_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.needs_mem) begin
					cmd.issue_rd = 1'b1;
					state_d      = S_MEM;
				end else if (slot_free) begin
					cmd.load_fail = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_MEM: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.load_fail) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// accepted item always moves to execution
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted item did not enter execution");

	// a produced result is presented next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.load_fail) |=> out_valid_q)
		else $error("result not presented");

	// a blocked commit waits with the old result still shown
	a_commit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEM && !slot_free) |=> (state_q == S_MEM && out_valid_q))
		else $error("commit left while output blocked");

endmodule

`default_nettype wire

// ===== sv/dha_dp.sv =====
`default_nettype none

module dha_dp import dha_pkg::*; #(
	parameter int DEPTH = DHA_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dha_cmd_t          cmd,
	output dha_sts_t               sts,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [LD_W-1:0]   local_desc,
	input  wire logic [PID_W-1:0]  owner_pid,
	input  wire logic [NODE_W-1:0] node_ref,
	input  wire logic [DESC_W-1:0] global_desc,
	output logic      [ST_W-1:0]   status,
	output logic      [DESC_W-1:0] result_desc,
	output logic                   entry_used,
	output logic      [LD_W-1:0]   entry_local_desc,
	output logic      [PID_W-1:0]  entry_pid,
	output logic      [NODE_W-1:0] entry_node
);

	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AWX    = AW + BIT_W;
	localparam int NW     = (DEPTH + WORD_W - 1) / WORD_W;
	localparam int NWB    = (NW > 1) ? $clog2(NW) : 1;
	localparam int DW     = LD_W + PID_W + NODE_W;
	localparam int LAST_N = DEPTH - (NW - 1) * WORD_W;
	localparam logic [WORD_W-1:0] ONE_W    = WORD_W'(1);
	localparam logic [WORD_W-1:0] LAST_PAD = ~((ONE_W << LAST_N) - ONE_W);
	localparam logic [16:0]       DEPTH_X  = 17'(DEPTH);

	// latched request
	logic [REQ_W-1:0]  req_q;
	logic [LD_W-1:0]   ld_q;
	logic [PID_W-1:0]  pid_q;
	logic [NODE_W-1:0] node_q;
	logic [DESC_W-1:0] gd_q;

	// bookkeeping
	logic [AW-1:0]  cnt_q;
	logic [NW-1:0]  full_q;
	logic [NWB-1:0] w_q;

	// output payload
	logic [ST_W-1:0]   out_st_q;
	logic [DESC_W-1:0] out_desc_q;
	logic              out_used_q;
	logic [LD_W-1:0]   out_ld_q;
	logic [PID_W-1:0]  out_pid_q;
	logic [NODE_W-1:0] out_node_q;

	// memory ports
	logic              dm_we, bm_we;
	logic [AW-1:0]     dm_waddr;
	logic [DW-1:0]     dm_wdata, dm_rdata;
	logic [NWB-1:0]    bm_waddr, bm_raddr;
	logic [WORD_W-1:0] bm_wdata, bm_rdata;

	// decoded request
	logic              is_alloc, is_free, is_get;
	logic              gd_ok;
	logic [AW-1:0]     gd_idx;
	logic [AWX-1:0]    gd_idx_x;
	logic [NWB-1:0]    gd_word;
	logic [BIT_W-1:0]  gd_bit;
	logic              found_any;
	logic [NWB-1:0]    found_w;
	logic              bit_found;
	logic [BIT_W-1:0]  alloc_bit;
	logic [AW-1:0]     alloc_idx;
	logic [WORD_W-1:0] set_word, clr_word;
	logic              clr_bm;

	assign is_alloc = (req_q == REQ_ALLOC);
	assign is_free  = (req_q == REQ_FREE);
	assign is_get   = (req_q == REQ_GET);

	// descriptor range check and entry index
	assign gd_ok    = (gd_q != '0) && (17'(gd_q) <= DEPTH_X);
	assign gd_idx   = AW'(gd_q - DESC_W'(1));
	assign gd_idx_x = AWX'(gd_idx);
	assign gd_word  = NWB'(gd_idx_x >> BIT_W);
	assign gd_bit   = gd_idx_x[BIT_W-1:0];

	// lowest bitmap word that still has a free entry
	always_comb begin
		found_any = 1'b0;
		found_w   = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				found_any = 1'b1;
				found_w   = NWB'(i);
			end
		end
	end

	// lowest free bit of the word read back
	always_comb begin
		bit_found = 1'b0;
		alloc_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!bm_rdata[i]) begin
				bit_found = 1'b1;
				alloc_bit = BIT_W'(i);
			end
		end
	end

	assign alloc_idx = AW'((AWX'(w_q) << BIT_W) | AWX'(alloc_bit));
	assign set_word  = bm_rdata | (ONE_W << alloc_bit);
	assign clr_word  = bm_rdata & ~(ONE_W << gd_bit);

	// status to the controller
	always_comb begin
		sts.clear_last = (cnt_q == AW'(DEPTH - 1));
		case (req_q) inside
			REQ_ALLOC:         sts.needs_mem = found_any;
			REQ_FREE, REQ_GET: sts.needs_mem = gd_ok;
			default:           sts.needs_mem = 1'b0;
		endcase
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q  <= req_type;
			ld_q   <= local_desc;
			pid_q  <= owner_pid;
			node_q <= node_ref;
			gd_q   <= global_desc;
		end
	end

	// word under work
	always_ff @(posedge clk) begin
		if (cmd.issue_rd) begin
			w_q <= is_alloc ? found_w : gd_word;
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear_step && !sts.clear_last) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// per-word full marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (cmd.commit && is_alloc) begin
			full_q[w_q] <= &set_word;
		end else if (cmd.commit && is_free) begin
			full_q[w_q] <= 1'b0;
		end
	end

	// memory write selection
	assign clr_bm   = cmd.clear_step && (AWX'(cnt_q) < AWX'(NW));
	assign dm_we    = cmd.clear_step || (cmd.commit && (is_alloc || is_free));
	assign dm_waddr = cmd.clear_step ? cnt_q : (is_alloc ? alloc_idx : gd_idx);
	assign dm_wdata = (cmd.clear_step || !is_alloc) ? '0 : {node_q, pid_q, ld_q};
	assign bm_we    = clr_bm || (cmd.commit && (is_alloc || is_free));
	assign bm_waddr = cmd.clear_step ? NWB'(cnt_q) : w_q;
	assign bm_raddr = is_alloc ? found_w : gd_word;

	always_comb begin
		if (cmd.clear_step) begin
			bm_wdata = (AWX'(cnt_q) == AWX'(NW - 1)) ? LAST_PAD : '0;
		end else if (is_alloc) begin
			bm_wdata = set_word;
		end else begin
			bm_wdata = clr_word;
		end
	end

	dha_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_data_ram (
		.clk  (clk),
		.we   (dm_we),
		.waddr(dm_waddr),
		.wdata(dm_wdata),
		.re   (cmd.issue_rd),
		.raddr(gd_idx),
		.rdata(dm_rdata)
	);

	dha_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NW)
	) u_bitmap_ram (
		.clk  (clk),
		.we   (bm_we),
		.waddr(bm_waddr),
		.wdata(bm_wdata),
		.re   (cmd.issue_rd),
		.raddr(bm_raddr),
		.rdata(bm_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_fail) begin
			out_st_q   <= is_alloc ? ST_FULL : ST_NOT_FOUND;
			out_desc_q <= '0;
			out_used_q <= 1'b0;
			out_ld_q   <= '0;
			out_pid_q  <= '0;
			out_node_q <= '0;
		end else if (cmd.commit) begin
			out_st_q   <= ST_OK;
			out_desc_q <= '0;
			out_used_q <= 1'b0;
			out_ld_q   <= '0;
			out_pid_q  <= '0;
			out_node_q <= '0;
			if (is_alloc) begin
				out_desc_q <= DESC_W'(17'(alloc_idx) + 17'd1);
			end else if (is_get) begin
				out_desc_q <= gd_q;
				out_used_q <= bm_rdata[gd_bit];
				out_ld_q   <= dm_rdata[LD_W-1:0];
				out_pid_q  <= dm_rdata[LD_W+PID_W-1:LD_W];
				out_node_q <= dm_rdata[DW-1:LD_W+PID_W];
			end
		end
	end

	assign status           = out_st_q;
	assign result_desc      = out_desc_q;
	assign entry_used       = out_used_q;
	assign entry_local_desc = out_ld_q;
	assign entry_pid        = out_pid_q;
	assign entry_node       = out_node_q;

	// the word picked for allocation was marked not full
	a_word_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue_rd && is_alloc) |-> !full_q[found_w])
		else $error("allocation picked a full word");

	// the word read back for allocation has a free bit
	a_bit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_alloc) |-> bit_found)
		else $error("allocation word has no free entry");

	// the clearing sweep never overlaps item work
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !(cmd.latch_req || cmd.commit || cmd.load_fail))
		else $error("item work during clearing sweep");

endmodule

`default_nettype wire

// ===== sv/descriptor_handle_allocator_top.sv =====
// channel   role     payload
// s_*       request  tuser: req_type; tdata: local_desc, owner_pid, node_ref, global_desc
// m_*       result   tuser: status; tdata: result_desc, entry_used, entry fields
//
// an item is accepted, then goes through a free-word search and memory read, then the
// bitmap and data memory write with the result loaded into the output register
// a request that fails its check skips the memory step
// after reset a clearing pass zeros both memories (bitmap pad bits set); no item is taken
// a stalled result holds the next item in its last step until the output frees
// the next request is taken while a finished result still waits on m_*
`default_nettype none

module descriptor_handle_allocator_top import dha_pkg::*; #(
	parameter int DEPTH = DHA_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// local_desc[31:0], owner_pid[47:32], node_ref[63:48], global_desc[74:64], zeros
	input  wire logic [79:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_desc[10:0], entry_used[11], entry_local_desc[43:12],
	// entry_pid[59:44], entry_node[75:60], zeros
	output logic      [79:0] m_tdata,
	// status[1:0]
	output logic      [1:0]  m_tuser
);

	dha_cmd_t          cmd;
	dha_sts_t          sts;
	logic [DESC_W-1:0] result_desc;
	logic              entry_used;
	logic [LD_W-1:0]   entry_local_desc;
	logic [PID_W-1:0]  entry_pid;
	logic [NODE_W-1:0] entry_node;

	// sequencing
	dha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table storage and search
	dha_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (s_tuser),
		.local_desc      (s_tdata[31:0]),
		.owner_pid       (s_tdata[47:32]),
		.node_ref        (s_tdata[63:48]),
		.global_desc     (s_tdata[74:64]),
		.status          (m_tuser),
		.result_desc     (result_desc),
		.entry_used      (entry_used),
		.entry_local_desc(entry_local_desc),
		.entry_pid       (entry_pid),
		.entry_node      (entry_node)
	);

	// result packing
	assign m_tdata = {4'd0, entry_node, entry_pid, entry_local_desc, entry_used, result_desc};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
	import dha_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = DHA_DEPTH;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int BACKLOG_HOLD = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// local_desc, owner_pid, node_ref, global_desc, zeros
	logic [79:0] s_tdata;
	// req_type
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// result_desc, entry_used, entry_local_desc, entry_pid, entry_node, zeros
	logic [79:0] m_tdata;
	// status
	logic [1:0]  m_tuser;

	// one expected response
	typedef struct {
		bit [ST_W-1:0]   status;
		bit [DESC_W-1:0] desc;
		bit              used;
		bit [LD_W-1:0]   ld;
		bit [PID_W-1:0]  pid;
		bit [NODE_W-1:0] node;
	} handle_result_t;

	// descriptor table shadow and the responses still owed by the block
	class handle_table_sb;
		bit                in_use [TABLE_DEPTH];
		bit [LD_W-1:0]     ld_mem [TABLE_DEPTH];
		bit [PID_W-1:0]    pid_mem [TABLE_DEPTH];
		bit [NODE_W-1:0]   node_mem [TABLE_DEPTH];
		handle_result_t    owed_q[$];
		int                errors;
		int                full_seen;

		// work out the response of an accepted request and update the table
		function void note_request(logic [REQ_W-1:0] req, logic [LD_W-1:0] ld,
				logic [PID_W-1:0] pid, logic [NODE_W-1:0] node, logic [DESC_W-1:0] gd);
			handle_result_t r;
			int idx;
			bit in_range;
			r = '{ST_NOT_FOUND, 0, 0, 0, 0, 0};
			in_range = (gd != 0) && (gd <= TABLE_DEPTH);
			idx = int'(gd) - 1;
			case (req)
				REQ_ALLOC: begin
					idx = lowest_free();
					if (idx < 0) begin
						r.status = ST_FULL;
						full_seen++;
					end else begin
						in_use[idx] = 1'b1;
						ld_mem[idx] = ld;
						pid_mem[idx] = pid;
						node_mem[idx] = node;
						r.status = ST_OK;
						r.desc = DESC_W'(idx + 1);
					end
				end
				REQ_FREE: begin
					if (in_range) begin
						in_use[idx] = 1'b0;
						ld_mem[idx] = '0;
						pid_mem[idx] = '0;
						node_mem[idx] = '0;
						r.status = ST_OK;
					end
				end
				REQ_GET: begin
					if (in_range) begin
						r = '{ST_OK, gd, in_use[idx], ld_mem[idx], pid_mem[idx], node_mem[idx]};
					end
				end
				default: ;
			endcase
			owed_q.push_back(r);
		endfunction

		// compare one response field by field with the oldest owed one
		function void check_result(logic [ST_W-1:0] st, logic [79:0] data);
			handle_result_t e;
			if (owed_q.size() == 0) begin
				$error("response with no request pending: status %0h data %0h", st, data);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			cmp_field("status", 32'(e.status), 32'(st));
			cmp_field("result_desc", 32'(e.desc), 32'(data[10:0]));
			cmp_field("entry_used", 32'(e.used), 32'(data[11]));
			cmp_field("entry_local_desc", e.ld, data[43:12]);
			cmp_field("entry_pid", 32'(e.pid), 32'(data[59:44]));
			cmp_field("entry_node", 32'(e.node), 32'(data[75:60]));
		endfunction

		function void cmp_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
			if (got_val !== exp_val) begin
				$error("%s mismatch: expected %0h actual %0h", name, exp_val, got_val);
				errors++;
			end
		endfunction

		function int lowest_free();
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (!in_use[i])
					return i;
			return -1;
		endfunction

		// descriptor of some entry in use, 0 when the table is empty
		function int pick_used();
			int start;
			start = $urandom_range(0, TABLE_DEPTH - 1);
			for (int k = 0; k < TABLE_DEPTH; k++)
				if (in_use[(start + k) % TABLE_DEPTH])
					return ((start + k) % TABLE_DEPTH) + 1;
			return 0;
		endfunction
	endclass

	handle_table_sb handles = new();

	int  items_sent;
	bit  backlog_req;
	int  burst_until;

	descriptor_handle_allocator_top #(
		.DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// clock and reset
	initial clk = 1'b0;

	always #6 clk = ~clk;

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one request until accepted, then note it and sometimes idle for a random gap
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [LD_W-1:0] ld,
			input logic [PID_W-1:0] pid, input logic [NODE_W-1:0] node,
			input logic [DESC_W-1:0] gd);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {5'b0, gd, node, pid, ld};
		do @(posedge clk); while (!s_tready);
		handles.note_request(req, ld, pid, node, gd);
		items_sent++;
		gap = pick_gap(items_sent < burst_until || (items_sent / 128) % 4 == 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// weighted random request; the rest is unused codes and bad descriptors
	task automatic send_random(input int alloc_w, input int free_w, input int get_w);
		int r;
		int gd;
		logic [REQ_W-1:0] req;
		r = $urandom_range(0, 99);
		gd = handles.pick_used();
		if (gd == 0 || $urandom_range(0, 99) < 20)
			gd = $urandom_range(1, TABLE_DEPTH);
		if (r < alloc_w) begin
			req = REQ_ALLOC;
			gd = $urandom_range(0, 2047);
		end else if (r < alloc_w + free_w) begin
			req = REQ_FREE;
		end else if (r < alloc_w + free_w + get_w) begin
			req = REQ_GET;
		end else begin
			case ($urandom_range(0, 2))
				0: req = REQ_UNUSED;
				1: req = REQ_FREE;
				default: req = REQ_GET;
			endcase
			gd = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(TABLE_DEPTH + 1, 2047);
		end
		send_request(req, LD_W'($urandom), PID_W'($urandom), NODE_W'($urandom),
			DESC_W'(gd));
	endtask

	// response receiver with random stalls and one long hold-off
	initial begin
		int stall_left;
		int hold_left;
		int rx_cycles;
		stall_left = 0;
		hold_left = 0;
		rx_cycles = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (backlog_req) begin
				backlog_req = 1'b0;
				hold_left = BACKLOG_HOLD;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				if ((rx_cycles / 500) % 3 != 0 && $urandom_range(0, 99) < 25)
					stall_left = pick_gap(1'b0);
				m_tready <= (stall_left == 0);
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			handles.check_result(m_tuser, m_tdata);
	end

	// stimulus
	initial begin
		int n;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_ALLOC;
		items_sent = 0;
		backlog_req = 1'b0;
		burst_until = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: extremes, every operation, reuse, bad descriptors
		send_request(REQ_GET, '0, '0, '0, 11'd1);
		send_request(REQ_ALLOC, '1, '1, '1, 11'd0);
		send_request(REQ_ALLOC, '0, '0, '0, 11'd2047);
		send_request(REQ_GET, '0, '0, '0, 11'd1);
		send_request(REQ_GET, '1, '1, '1, 11'd2);
		send_request(REQ_FREE, '0, '0, '0, 11'd1);
		send_request(REQ_GET, '0, '0, '0, 11'd1);
		send_request(REQ_ALLOC, 32'hA5A5_5A5A, 16'h8001, 16'h0000, 11'd0);
		send_request(REQ_GET, '0, '0, '0, 11'd1);
		send_request(REQ_FREE, '0, '0, '0, 11'd0);
		send_request(REQ_GET, '0, '0, '0, 11'd0);
		send_request(REQ_FREE, '0, '0, '0, 11'(TABLE_DEPTH + 1));
		send_request(REQ_GET, '1, '1, '1, 11'd2047);
		send_request(REQ_GET, '0, '0, '0, 11'(TABLE_DEPTH));
		send_request(REQ_FREE, '0, '0, '0, 11'(TABLE_DEPTH));
		send_request(REQ_GET, '0, '0, '0, 11'(TABLE_DEPTH + 1));
		send_request(REQ_UNUSED, '1, '1, '1, 11'd2047);
		send_request(REQ_FREE, '0, '0, '0, 11'd3);
		send_request(REQ_ALLOC, 32'h0000_0001, 16'h7FFE, 16'h1234, 11'd0);
		send_request(REQ_GET, '0, '0, '0, 11'd3);

		// fill until the table has reported full many times
		n = 0;
		while (handles.full_seen < 25 && n < 1600) begin
			if (n == 300) begin
				backlog_req = 1'b1;
				burst_until = items_sent + 60;
			end
			send_random(88, 3, 7);
			n++;
		end

		// drain, then mixed traffic
		repeat (500) send_random(20, 60, 15);
		repeat (300) send_random(40, 30, 25);
		s_tvalid <= 1'b0;

		// wait for every owed response, then a few more cycles
		while (handles.owed_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (handles.errors == 0)
			$display("descriptor_handle_allocator_top verification clean");
		else
			$display("descriptor_handle_allocator_top verification failed");
		$finish;
	end

	// run limit
	initial begin
		#8_000_000;
		$display("descriptor_handle_allocator_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
